// ===== rtl/core/udiv_pkg.sv =====
// Shared constants for the 128-bit unsigned divider.
`default_nettype none
package udiv_pkg;

  localparam int FIELD_BITS = 64;
  localparam int MAX_BITS   = 2 * FIELD_BITS;

  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [MAX_BITS-1:0]   wide_t;

endpackage
`default_nettype wire

// ===== rtl/core/unsigned_divider_128_top.sv =====
// Top level of the pipelined unsigned divider.
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, OPERAND_BITS stages,
// and a new operand pair is taken every cycle while req_stall is low. Each stage
// holds one trial subtract of OPERAND_BITS+1 bits; empty stages close up under a
// stall. Operand bits at or above OPERAND_BITS are ignored. A zero divisor sets
// divide_by_zero and returns zero quotient and remainder.
module unsigned_divider_128_top #(
  parameter int OPERAND_BITS = 128
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  output logic                        req_stall,
  input  wire udiv_pkg::field_t       dividend_high,
  input  wire udiv_pkg::field_t       dividend_low,
  input  wire udiv_pkg::field_t       divisor_high,
  input  wire udiv_pkg::field_t       divisor_low,
  output logic                        rsp_valid,
  input  wire logic                   rsp_stall,
  output udiv_pkg::field_t            quotient_high,
  output udiv_pkg::field_t            quotient_low,
  output udiv_pkg::field_t            remainder_high,
  output udiv_pkg::field_t            remainder_low,
  output logic                        divide_by_zero
);

  localparam int N = OPERAND_BITS;
  localparam int W = udiv_pkg::MAX_BITS;
  localparam int F = udiv_pkg::FIELD_BITS;

  logic [N-1:0] rem_s [0:N];
  logic [N-1:0] dq_s  [0:N];
  logic [N-1:0] dvs_s [0:N];
  logic         dz_s  [0:N];
  logic         vld_s [0:N];
  logic         stl_s [0:N];

  udiv_pkg::wide_t dividend_full;
  udiv_pkg::wide_t divisor_full;
  udiv_pkg::wide_t quot_wide;
  udiv_pkg::wide_t rem_wide;

  assign dividend_full = {dividend_high, dividend_low};
  assign divisor_full  = {divisor_high, divisor_low};

  assign rem_s[0] = '0;
  assign dq_s[0]  = dividend_full[N-1:0];
  assign dvs_s[0] = divisor_full[N-1:0];
  assign dz_s[0]  = (divisor_full[N-1:0] == '0);
  assign vld_s[0] = req_valid;
  assign req_stall = stl_s[0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    udiv_stage #(.N(N)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld_s[k]),
      .in_stall  (stl_s[k]),
      .in_rem    (rem_s[k]),
      .in_dq     (dq_s[k]),
      .in_dvs    (dvs_s[k]),
      .in_dz     (dz_s[k]),
      .out_valid (vld_s[k+1]),
      .out_stall (stl_s[k+1]),
      .out_rem   (rem_s[k+1]),
      .out_dq    (dq_s[k+1]),
      .out_dvs   (dvs_s[k+1]),
      .out_dz    (dz_s[k+1])
    );
  end

  assign stl_s[N] = rsp_stall;
  assign rsp_valid = vld_s[N];
  assign divide_by_zero = dz_s[N];

  always_comb begin
    quot_wide = W'(dq_s[N]);
    rem_wide  = W'(rem_s[N]);
    if (dz_s[N]) begin
      quot_wide = '0;
      rem_wide  = '0;
    end
  end

  assign quotient_high  = quot_wide[W-1:F];
  assign quotient_low   = quot_wide[F-1:0];
  assign remainder_high = rem_wide[W-1:F];
  assign remainder_low  = rem_wide[F-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/udiv_stage.sv =====
// One restoring-division step with its own pipeline register and handshake.
`default_nettype none
module udiv_stage #(
  parameter int N = 128
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [N-1:0] in_rem,
  input  wire logic [N-1:0] in_dq,
  input  wire logic [N-1:0] in_dvs,
  input  wire logic         in_dz,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [N-1:0]      out_rem,
  output logic [N-1:0]      out_dq,
  output logic [N-1:0]      out_dvs,
  output logic              out_dz
);

  logic [N:0]   shifted;
  logic [N+1:0] trial;
  logic         ge;
  logic [N-1:0] rem_next;
  logic [N-1:0] dq_next;
  logic         load;

  always_comb begin
    shifted  = {in_rem, in_dq[N-1]};
    trial    = {1'b0, shifted} - {2'b00, in_dvs};
    ge       = ~trial[N+1];
    rem_next = ge ? trial[N-1:0] : shifted[N-1:0];
    dq_next  = {in_dq[N-2:0], ge};
  end

  assign in_stall = out_valid & out_stall;
  assign load     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rem <= rem_next;
      out_dq  <= dq_next;
      out_dvs <= in_dvs;
      out_dz  <= in_dz;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/udiv_checker.sv =====
// Port-level checks for the pipelined divider and their binding.
`default_nettype none
module udiv_checker #(
  parameter int OPERAND_BITS = 128
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_valid,
  input wire logic             req_stall,
  input wire udiv_pkg::field_t dividend_high,
  input wire udiv_pkg::field_t dividend_low,
  input wire udiv_pkg::field_t divisor_high,
  input wire udiv_pkg::field_t divisor_low,
  input wire logic             rsp_valid,
  input wire logic             rsp_stall,
  input wire udiv_pkg::field_t quotient_high,
  input wire udiv_pkg::field_t quotient_low,
  input wire udiv_pkg::field_t remainder_high,
  input wire udiv_pkg::field_t remainder_low,
  input wire logic             divide_by_zero
);

  logic [OPERAND_BITS-1:0] divisor_seen;
  assign divisor_seen = OPERAND_BITS'({divisor_high, divisor_low});

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && divide_by_zero |->
      quotient_high == '0 && quotient_low == '0 &&
      remainder_high == '0 && remainder_low == '0)
    else $error("divide by zero item carries nonzero result");

  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled while the pipeline can advance");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(quotient_low) &&
      $stable(remainder_low) && $stable(divide_by_zero))
    else $error("stalled result changed");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(dividend_high) &&
      $stable(dividend_low) && $stable(divisor_seen))
    else $error("stalled input item changed");

endmodule

bind unsigned_divider_128_top udiv_checker #(.OPERAND_BITS(OPERAND_BITS)) u_udiv_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_stall      (req_stall),
  .dividend_high  (dividend_high),
  .dividend_low   (dividend_low),
  .divisor_high   (divisor_high),
  .divisor_low    (divisor_low),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .quotient_high  (quotient_high),
  .quotient_low   (quotient_low),
  .remainder_high (remainder_high),
  .remainder_low  (remainder_low),
  .divide_by_zero (divide_by_zero)
);
`default_nettype wire
